// ----- rtl/core/rsb_pkg.sv -----
// Shared types and constants for the rectangle subtraction block.
package rsb_pkg;

    localparam int CB = 16;
    localparam int NBANDS = 4;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Band slots, in output order
    localparam int BAND_ABOVE = 0;
    localparam int BAND_BELOW = 1;
    localparam int BAND_LEFT  = 2;
    localparam int BAND_RIGHT = 3;

    typedef logic signed [CB-1:0] coord_t;
    typedef logic signed [CB:0]   wide_t;

    typedef struct packed {
        coord_t left;
        coord_t top;
        coord_t width;
        coord_t height;
    } rsb_piece_t;

    typedef struct packed {
        rsb_piece_t [NBANDS-1:0] piece;
        logic [NBANDS-1:0]       mask;
    } rsb_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } rsb_qstat_t;

endpackage

// ----- rtl/core/rsb_front.sv -----
// Front end: takes rectangle pairs, forms the intersection and classifies the bands.
module rsb_front
    import rsb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  coord_t      a_left,
    input  coord_t      a_top,
    input  coord_t      a_width,
    input  coord_t      a_height,
    input  coord_t      b_left,
    input  coord_t      b_top,
    input  coord_t      b_width,
    input  coord_t      b_height,
    input  rsb_qstat_t  qstat,
    output logic        push,
    output rsb_entry_t  push_entry
);

    logic   s1_valid_reg, s1_valid_next;
    coord_t ax_reg, ay_reg, aw_reg, ah_reg;
    wide_t  ax_end_reg, ay_end_reg;
    coord_t x0_reg, y0_reg, x1_reg, y1_reg;
    logic   a_empty_reg, b_empty_reg;

    wide_t  a_xend, a_yend, b_xend, b_yend;
    coord_t a_xw, a_yw, b_xw, b_yw;
    logic   s1_adv;

    wide_t  dx, dy, below_h, right_w;
    wide_t  x1e, y1e;
    logic   ok_x, ok_y, i_empty;
    coord_t ih;
    rsb_entry_t e;

    // stage 1: edge sums and the intersection corners
    always_comb
    begin
        a_xend = wide_t'(a_left) + wide_t'(a_width);
        a_yend = wide_t'(a_top) + wide_t'(a_height);
        b_xend = wide_t'(b_left) + wide_t'(b_width);
        b_yend = wide_t'(b_top) + wide_t'(b_height);
        a_xw = a_xend[CB-1:0];
        a_yw = a_yend[CB-1:0];
        b_xw = b_xend[CB-1:0];
        b_yw = b_yend[CB-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            ax_reg      <= a_left;
            ay_reg      <= a_top;
            aw_reg      <= a_width;
            ah_reg      <= a_height;
            ax_end_reg  <= a_xend;
            ay_end_reg  <= a_yend;
            x0_reg      <= (a_left > b_left) ? a_left : b_left;
            y0_reg      <= (a_top > b_top) ? a_top : b_top;
            x1_reg      <= (a_xw < b_xw) ? a_xw : b_xw;
            y1_reg      <= (a_yw < b_yw) ? a_yw : b_yw;
            a_empty_reg <= a_width[CB-1] || (a_width == '0) || a_height[CB-1] || (a_height == '0);
            b_empty_reg <= b_width[CB-1] || (b_width == '0) || b_height[CB-1] || (b_height == '0);
        end
    end

    // stage 2: band tests, straight into the queue
    always_comb
    begin
        dx = wide_t'(x1_reg) - wide_t'(x0_reg);
        dy = wide_t'(y1_reg) - wide_t'(y0_reg);
        // intersection size must be positive after wrapping to CB bits
        ok_x = !dx[CB] && !dx[CB-1] && (dx != '0);
        ok_y = !dy[CB] && !dy[CB-1] && (dy != '0);
        i_empty = b_empty_reg || !ok_x || !ok_y;
        ih = dy[CB-1:0];
        // edges of a non-empty intersection never wrap
        x1e = wide_t'(x1_reg);
        y1e = wide_t'(y1_reg);
        below_h = ay_end_reg - y1e;
        right_w = ax_end_reg - x1e;

        e.piece[BAND_ABOVE] = '{left: ax_reg, top: ay_reg, width: aw_reg,
                                height: coord_t'(y0_reg - ay_reg)};
        e.piece[BAND_BELOW] = '{left: ax_reg, top: y1_reg, width: aw_reg,
                                height: below_h[CB-1:0]};
        e.piece[BAND_LEFT]  = '{left: ax_reg, top: y0_reg,
                                width: coord_t'(x0_reg - ax_reg), height: ih};
        e.piece[BAND_RIGHT] = '{left: x1_reg, top: y0_reg,
                                width: right_w[CB-1:0], height: ih};
        e.mask = '0;
        priority if (a_empty_reg)
        begin
            e.mask = '0;
        end
        else if (i_empty)
        begin
            e.piece[BAND_ABOVE] = '{left: ax_reg, top: ay_reg, width: aw_reg,
                                    height: ah_reg};
            e.mask[BAND_ABOVE] = 1'b1;
        end
        else
        begin
            e.mask[BAND_ABOVE] = y0_reg > ay_reg;
            e.mask[BAND_BELOW] = y1e < ay_end_reg;
            e.mask[BAND_LEFT]  = x0_reg > ax_reg;
            e.mask[BAND_RIGHT] = x1e < ax_end_reg;
        end

        // items with no pieces are dropped without a queue slot
        s1_adv        = !s1_valid_reg || (e.mask == '0) || !qstat.full;
        push          = s1_valid_reg && (e.mask != '0) && !qstat.full;
        push_entry    = e;
        item_ready    = s1_adv;
        s1_valid_next = item_valid ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    end

endmodule

// ----- rtl/core/rsb_queue.sv -----
// Short queue of classified entries between the front and back ends.
module rsb_queue
    import rsb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  rsb_entry_t  push_entry,
    input  logic        pop,
    output rsb_entry_t  head,
    output rsb_qstat_t  qstat
);

    rsb_entry_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    always_comb
    begin
        qstat.full  = (count_reg == QCNT_W'(QDEPTH));
        qstat.empty = (count_reg == '0);
        do_push     = push && !qstat.full;
        do_pop      = pop && !qstat.empty;
        wr_ptr_next = do_push ? QPTR_W'((wr_ptr_reg + 1'b1) % QDEPTH) : wr_ptr_reg;
        rd_ptr_next = do_pop ? QPTR_W'((rd_ptr_reg + 1'b1) % QDEPTH) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
        head        = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- rtl/core/rsb_back.sv -----
// Back end: walks the band mask of the head entry and gives one piece per transfer.
module rsb_back
    import rsb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rsb_entry_t  head,
    input  rsb_qstat_t  qstat,
    output logic        pop,
    output logic        piece_valid,
    input  logic        piece_ready,
    output coord_t      piece_left,
    output coord_t      piece_top,
    output coord_t      piece_width,
    output coord_t      piece_height,
    output logic        piece_last
);

    logic              started_reg, started_next;
    logic [NBANDS-1:0] rem_reg, rem_next;
    logic              out_valid_reg, out_valid_next;
    rsb_piece_t        out_piece_reg;
    logic              out_last_reg;

    logic [NBANDS-1:0] cur_mask, sel, left_over;
    rsb_piece_t        sel_piece;
    logic              load;

    always_comb
    begin
        cur_mask  = started_reg ? rem_reg : head.mask;
        // lowest set bit first: above, below, left, right
        sel       = cur_mask & (~cur_mask + 1'b1);
        left_over = cur_mask & ~sel;
        sel_piece = head.piece[BAND_ABOVE];
        for (int i = 0; i < NBANDS; i++)
        begin
            if (sel[i])
            begin
                sel_piece = head.piece[i];
            end
        end

        load           = !qstat.empty && (!out_valid_reg || piece_ready);
        pop            = load && (left_over == '0);
        started_next   = load ? (left_over != '0) : started_reg;
        rem_next       = load ? left_over : rem_reg;
        out_valid_next = load ? 1'b1 : (piece_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            started_reg   <= started_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_piece_reg <= sel_piece;
            out_last_reg  <= (left_over == '0);
        end
    end

    assign piece_valid  = out_valid_reg;
    assign piece_left   = out_piece_reg.left;
    assign piece_top    = out_piece_reg.top;
    assign piece_width  = out_piece_reg.width;
    assign piece_height = out_piece_reg.height;
    assign piece_last   = out_last_reg;

endmodule

// ----- rtl/core/rect_subtract_bands.sv -----
// The first piece of an item passes the stage-1 registers, the queue and the output register
// before it is offered; further pieces follow one per cycle while piece_ready is high. The
// front end takes a new pair every cycle while the 4-entry queue has room; the output port
// sets sustained throughput, as a pair gives 1 to 4 pieces (one giving none takes no queue
// slot). Reset (rst_n, async) empties the pipeline and queue; no clearing pass is needed.
module rect_subtract_bands
    import rsb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   item_valid,
    output logic   item_ready,
    input  coord_t a_left,
    input  coord_t a_top,
    input  coord_t a_width,
    input  coord_t a_height,
    input  coord_t b_left,
    input  coord_t b_top,
    input  coord_t b_width,
    input  coord_t b_height,
    output logic   piece_valid,
    input  logic   piece_ready,
    output coord_t piece_left,
    output coord_t piece_top,
    output coord_t piece_width,
    output coord_t piece_height,
    output logic   piece_last
);

    rsb_qstat_t qstat;
    logic       push, pop;
    rsb_entry_t push_entry, head;

    rsb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .a_left     (a_left),
        .a_top      (a_top),
        .a_width    (a_width),
        .a_height   (a_height),
        .b_left     (b_left),
        .b_top      (b_top),
        .b_width    (b_width),
        .b_height   (b_height),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    rsb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    rsb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .qstat        (qstat),
        .pop          (pop),
        .piece_valid  (piece_valid),
        .piece_ready  (piece_ready),
        .piece_left   (piece_left),
        .piece_top    (piece_top),
        .piece_width  (piece_width),
        .piece_height (piece_height),
        .piece_last   (piece_last)
    );

endmodule
